FILE: design/tlkc_pkg.sv
// ============================================================================
// tlkc_pkg: shared types and constants of the keyed timestamp cache
// Sizes, operation and status codes, and the structs passed between modules.
// ============================================================================
package tlkc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = 5;
    localparam int KEY_W       = 64;
    localparam int STAMP_W     = 32;
    localparam int HANDLE_W    = 16;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_INVAL  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_HIT         = 3'd0,
        STAT_MISS        = 3'd1,
        STAT_INSERTED    = 3'd2,
        STAT_EVICTED     = 3'd3,
        STAT_PRESENT     = 3'd4,
        STAT_REFUSED     = 3'd5,
        STAT_INVALIDATED = 3'd6
    } t_status;

    typedef struct packed {
        t_mode                mode;
        logic [KEY_W-1:0]     key;
        logic [STAMP_W-1:0]   stamp;
        logic [HANDLE_W-1:0]  handle;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  found_handle;
        logic                 evicted_valid;
        logic [HANDLE_W-1:0]  evicted_handle;
        logic [CNT_W-1:0]     removed_count;
        logic [CNT_W-1:0]     occupancy;
    } t_result;

    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic [STAMP_W-1:0]   stamp;
        logic [HANDLE_W-1:0]  handle;
    } t_slot;

    // fill: write all fields and set valid; touch: stamp only; kill: clear valid
    typedef struct packed {
        logic                 fill;
        logic                 touch;
        logic                 kill;
        logic [IDX_W-1:0]     idx;
        logic [KEY_W-1:0]     key;
        logic [STAMP_W-1:0]   stamp;
        logic [HANDLE_W-1:0]  handle;
    } t_wr_req;

endpackage

FILE: design/timestamp_lru_keyed_cache_core.sv
// ============================================================================
// timestamp_lru_keyed_cache_core: fully associative keyed cache, stamp LRU
// Lookup with restamp, insert with least-recently-stamped replacement, and
// invalidation of entries stamped before a threshold.
// ============================================================================
//
// Channel   Direction  Handshake                Carries
// s_*       in         i_s_tvalid/o_s_tready    one request: mode, key, stamp, handle
// m_*       out        o_m_tvalid/i_m_tready    one result per request
// cfg_*     in         i_cfg_valid/o_cfg_ready  capacity register write
//
// A result reaches the output register after the scan and the decide state: the
// scan walks every slot in turn through the shared key and stamp comparators,
// then a decide and write-back state follows. Input ready is low while a
// request is in work and returns the cycle after its result is handed on, so a
// new request is not taken before the last one is through; the scan length is
// set by the slot count, not by the occupancy. A stalled result holds the engine
// in its decide state until the output register frees. Reset is synchronous and
// active low; it clears all slot valid bits and sets capacity to ten.
//
module timestamp_lru_keyed_cache_core
    import tlkc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request channel
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,  // key[63:0], stamp[95:64], handle[111:96]
    input  logic [1:0]   i_s_tuser,  // mode[1:0]
    // result channel
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,  // found_handle[15:0], evicted_valid[16],
                                     // evicted_handle[32:17], removed_count[37:33],
                                     // occupancy[42:38], zero fill[47:43]
    output logic [2:0]   o_m_tuser,  // status[2:0]
    // capacity register write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [4:0]   i_cfg_data
);

    logic [CNT_W-1:0] r_capacity;
    logic             r_out_valid;
    t_result          r_out;

    t_request         req;
    t_result          res;
    t_slot            slot;
    t_wr_req          wr;
    logic [IDX_W-1:0] rd_idx;
    logic             busy;
    logic             done;
    logic             start;
    logic             res_ready;

    // The register is always writable; a zero write is dropped and values
    // above the slot count saturate.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid && (i_cfg_data != '0)) begin
            r_capacity <= (i_cfg_data > CAP_MAX) ? CAP_MAX : i_cfg_data;
        end
    end

    // Unpack the request.
    assign req.mode   = t_mode'(i_s_tuser);
    assign req.key    = i_s_tdata[63:0];
    assign req.stamp  = i_s_tdata[95:64];
    assign req.handle = i_s_tdata[111:96];

    assign o_s_tready = !busy;
    assign start      = i_s_tvalid && !busy;

    // The output register frees when empty or when its result is taken.
    assign res_ready = !r_out_valid || i_m_tready;

    tlkc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_capacity  (r_capacity),
        .i_res_ready (res_ready),
        .o_busy      (busy),
        .o_done      (done),
        .o_res       (res),
        .o_rd_idx    (rd_idx),
        .i_slot      (slot),
        .o_wr        (wr)
    );

    tlkc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (rd_idx),
        .o_rd_slot (slot),
        .i_wr      (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {5'd0, r_out.occupancy, r_out.removed_count,
                         r_out.evicted_handle, r_out.evicted_valid, r_out.found_handle};

endmodule

FILE: design/tlkc_store.sv
// ============================================================================
// tlkc_store: slot storage of the keyed timestamp cache
// Key, stamp and handle per slot, plus valid bits; one registered read port
// and one write port.
// ============================================================================
module tlkc_store
    import tlkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_slot            o_rd_slot,
    input  t_wr_req          i_wr
);

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]       r_key    [MAX_ENTRIES];
    logic [STAMP_W-1:0]     r_stamp  [MAX_ENTRIES];
    logic [HANDLE_W-1:0]    r_handle [MAX_ENTRIES];
    t_slot                  r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.fill) begin
            r_valid[i_wr.idx] <= 1'b1;
        end else if (i_wr.kill) begin
            r_valid[i_wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.fill) begin
            r_key[i_wr.idx]    <= i_wr.key;
            r_handle[i_wr.idx] <= i_wr.handle;
        end
        if (i_wr.fill || i_wr.touch) begin
            r_stamp[i_wr.idx] <= i_wr.stamp;
        end
    end

    // The read data shows up the cycle after its address.
    always_ff @(posedge i_clk) begin
        r_rd_slot.valid  <= r_valid[i_rd_idx];
        r_rd_slot.key    <= r_key[i_rd_idx];
        r_rd_slot.stamp  <= r_stamp[i_rd_idx];
        r_rd_slot.handle <= r_handle[i_rd_idx];
    end

    assign o_rd_slot = r_rd_slot;

endmodule

FILE: design/tlkc_engine.sv
// ============================================================================
// tlkc_engine: scan sequencer of the keyed timestamp cache
// Walks all slots with one key comparator and one shared stamp comparator.
// ============================================================================
module tlkc_engine
    import tlkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_request         i_req,
    input  logic [CNT_W-1:0] i_capacity,
    input  logic             i_res_ready,
    output logic             o_busy,
    output logic             o_done,
    output t_result          o_res,
    output logic [IDX_W-1:0] o_rd_idx,
    input  t_slot            i_slot,
    output t_wr_req          o_wr
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    t_request              r_req, n_req;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_found_idx, n_found_idx;
    logic [HANDLE_W-1:0]   r_found_handle, n_found_handle;
    logic                  r_free_ok, n_free_ok;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                  r_old_ok, n_old_ok;
    logic [IDX_W-1:0]      r_old_idx, n_old_idx;
    logic [STAMP_W-1:0]    r_min, n_min;
    logic [HANDLE_W-1:0]   r_old_handle, n_old_handle;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_removed, n_removed;

    logic                  key_eq;
    logic [STAMP_W-1:0]    cmp_a, cmp_b;
    logic                  cmp_lt;

    // The one stamp comparator: slot stamp against running minimum or the
    // request stamp while scanning, then minimum against request stamp.
    always_comb begin
        if (r_state == S_DECIDE) begin
            cmp_a = r_min;
            cmp_b = r_req.stamp;
        end else begin
            cmp_a = i_slot.stamp;
            cmp_b = (r_req.mode == MODE_INSERT) ? r_min : r_req.stamp;
        end
    end
    assign cmp_lt = cmp_a < cmp_b;
    assign key_eq = i_slot.valid && (i_slot.key == r_req.key);

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_req          = r_req;
        n_found        = r_found;
        n_found_idx    = r_found_idx;
        n_found_handle = r_found_handle;
        n_free_ok      = r_free_ok;
        n_free_idx     = r_free_idx;
        n_old_ok       = r_old_ok;
        n_old_idx      = r_old_idx;
        n_min          = r_min;
        n_old_handle   = r_old_handle;
        n_count        = r_count;
        n_removed      = r_removed;
        o_done         = 1'b0;
        o_res          = '0;
        o_res.status   = STAT_MISS;
        o_res.occupancy = r_count;
        o_wr           = '0;
        o_wr.key       = r_req.key;
        o_wr.stamp     = r_req.stamp;
        o_wr.handle    = r_req.handle;
        o_wr.idx       = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req     = i_req;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_old_ok  = 1'b0;
                    n_count   = '0;
                    n_removed = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_slot.valid) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (key_eq && !r_found) begin
                    n_found        = 1'b1;
                    n_found_idx    = r_idx;
                    n_found_handle = i_slot.handle;
                end
                if (!i_slot.valid && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_idx;
                end
                if (r_req.mode == MODE_INSERT && i_slot.valid && (!r_old_ok || cmp_lt)) begin
                    n_old_ok     = 1'b1;
                    n_old_idx    = r_idx;
                    n_min        = i_slot.stamp;
                    n_old_handle = i_slot.handle;
                end
                if (r_req.mode == MODE_INVAL && i_slot.valid && cmp_lt) begin
                    o_wr.kill = 1'b1;
                    n_removed = r_removed + CNT_W'(1);
                end
                if (r_idx == IDX_LAST) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DECIDE: begin
                if (i_res_ready) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                    case (r_req.mode)
                        MODE_LOOKUP: begin
                            if (r_found) begin
                                o_res.status       = STAT_HIT;
                                o_res.found_handle = r_found_handle;
                                o_wr.touch         = 1'b1;
                                o_wr.idx           = r_found_idx;
                            end
                        end
                        MODE_INSERT: begin
                            if (r_found) begin
                                o_res.status = STAT_PRESENT;
                            end else if (r_count < i_capacity) begin
                                if (r_free_ok) begin
                                    o_res.status    = STAT_INSERTED;
                                    o_res.occupancy = r_count + CNT_W'(1);
                                    o_wr.fill       = 1'b1;
                                    o_wr.idx        = r_free_idx;
                                end else begin
                                    o_res.status = STAT_REFUSED;
                                end
                            end else if (r_old_ok && cmp_lt) begin
                                o_res.status         = STAT_EVICTED;
                                o_res.evicted_valid  = 1'b1;
                                o_res.evicted_handle = r_old_handle;
                                o_wr.fill            = 1'b1;
                                o_wr.idx             = r_old_idx;
                            end else begin
                                o_res.status = STAT_REFUSED;
                            end
                        end
                        MODE_INVAL: begin
                            o_res.status        = STAT_INVALIDATED;
                            o_res.removed_count = r_removed;
                            o_res.occupancy     = r_count - r_removed;
                        end
                        default: begin
                            o_res.status = STAT_MISS;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx          <= n_idx;
        r_req          <= n_req;
        r_found        <= n_found;
        r_found_idx    <= n_found_idx;
        r_found_handle <= n_found_handle;
        r_free_ok      <= n_free_ok;
        r_free_idx     <= n_free_idx;
        r_old_ok       <= n_old_ok;
        r_old_idx      <= n_old_idx;
        r_min          <= n_min;
        r_old_handle   <= n_old_handle;
        r_count        <= n_count;
        r_removed      <= n_removed;
    end

    assign o_busy   = (r_state != S_IDLE);
    // The store read is registered, so the address runs one slot ahead.
    assign o_rd_idx = n_idx;

endmodule
